[rtl/core/mtbs_pkg.sv]
`timescale 1ns / 1ps
package mtbs_pkg;

  // Field widths
  localparam int IDX_W    = 16;
  localparam int POS_W    = 24;
  localparam int MARGIN_W = 16;
  localparam int COUNT_W  = 17;
  localparam int SUM_W    = 26;

  // Bitmap geometry: one memory row holds this many vertex marks
  localparam int MARK_ROW_W   = 64;
  localparam int MARK_BIT_W   = $clog2(MARK_ROW_W);
  localparam int MAX_VERTICES_DEF = 65536;

  // Face count saturates at the smaller of the limit and the field maximum
  localparam int MAX_FACES    = 65536;
  localparam int FIELD17_MAX  = 131071;
  localparam int FACE_CAP     = (MAX_FACES < FIELD17_MAX) ? MAX_FACES : FIELD17_MAX;

  // Stream widths
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 40;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_CHECK_ON = 3'd7;

  localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RESET = 16'd26;

  typedef struct packed {
    logic signed [POS_W-1:0] min_x;
    logic signed [POS_W-1:0] min_y;
    logic signed [POS_W-1:0] min_z;
    logic signed [POS_W-1:0] max_x;
    logic signed [POS_W-1:0] max_y;
    logic signed [POS_W-1:0] max_z;
    logic [MARGIN_W-1:0]     margin;
    logic                    check_on;
  } box_cfg_t;

  typedef enum logic [1:0] {
    MARK_NONE,
    MARK_READ,
    MARK_SET,
    MARK_CLEAR
  } mark_op_t;

  typedef struct packed {
    mark_op_t              op;
    logic [MARK_BIT_W-1:0] bit_sel;
  } mark_cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_MARK_RD,
    S_MARK_WR,
    S_EMIT
  } ctrl_state_t;

endpackage

[rtl/core/mtbs_geom.sv]
`timescale 1ns / 1ps
module mtbs_geom (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           corner_load,
  input  logic                           tri_clear,
  input  logic signed [mtbs_pkg::POS_W-1:0] pos_x,
  input  logic signed [mtbs_pkg::POS_W-1:0] pos_y,
  input  logic signed [mtbs_pkg::POS_W-1:0] pos_z,
  input  mtbs_pkg::box_cfg_t             box,
  output logic                           keep
);
  import mtbs_pkg::*;

  localparam int WB_W = POS_W + 1;   // widened bound
  localparam int CB_W = POS_W + 3;   // three times widened bound, and sums

  logic signed [WB_W-1:0] hi_x, hi_y, hi_z, lo_x, lo_y, lo_z;
  logic signed [WB_W-1:0] margin_s;
  logic signed [CB_W-1:0] hi3_x, hi3_y, hi3_z, lo3_x, lo3_y, lo3_z;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic signed [CB_W-1:0] sx, sy, sz;
  logic                   outside;
  logic                   corner_out;
  logic                   cent_out;

  // Widen the box by the margin on every side
  always_comb begin
    margin_s = WB_W'($signed({1'b0, box.margin}));
    hi_x = WB_W'(box.max_x) + margin_s;
    hi_y = WB_W'(box.max_y) + margin_s;
    hi_z = WB_W'(box.max_z) + margin_s;
    lo_x = WB_W'(box.min_x) - margin_s;
    lo_y = WB_W'(box.min_y) - margin_s;
    lo_z = WB_W'(box.min_z) - margin_s;
    hi3_x = CB_W'(hi_x) + (CB_W'(hi_x) <<< 1);
    hi3_y = CB_W'(hi_y) + (CB_W'(hi_y) <<< 1);
    hi3_z = CB_W'(hi_z) + (CB_W'(hi_z) <<< 1);
    lo3_x = CB_W'(lo_x) + (CB_W'(lo_x) <<< 1);
    lo3_y = CB_W'(lo_y) + (CB_W'(lo_y) <<< 1);
    lo3_z = CB_W'(lo_z) + (CB_W'(lo_z) <<< 1);
  end

  // Test the arriving corner against the widened box
  always_comb begin
    corner_out = (WB_W'(pos_x) > hi_x) || (WB_W'(pos_x) < lo_x) ||
                 (WB_W'(pos_y) > hi_y) || (WB_W'(pos_y) < lo_y) ||
                 (WB_W'(pos_z) > hi_z) || (WB_W'(pos_z) < lo_z);
  end

  // Accumulate coordinate sums and the outside flag over the triangle
  always_ff @(posedge clk) begin
    if (rst || tri_clear) begin
      sum_x   <= '0;
      sum_y   <= '0;
      sum_z   <= '0;
      outside <= 1'b0;
    end else if (corner_load) begin
      sum_x   <= sum_x + SUM_W'(pos_x);
      sum_y   <= sum_y + SUM_W'(pos_y);
      sum_z   <= sum_z + SUM_W'(pos_z);
      outside <= outside | corner_out;
    end
  end

  // Compare centroid exactly: sum against three times each bound
  always_comb begin
    sx = CB_W'(sum_x);
    sy = CB_W'(sum_y);
    sz = CB_W'(sum_z);
    cent_out = (sx > hi3_x) || (sx < lo3_x) ||
               (sy > hi3_y) || (sy < lo3_y) ||
               (sz > hi3_z) || (sz < lo3_z);
    keep = !box.check_on || !outside || !cent_out;
  end

endmodule

[rtl/core/mtbs_marks.sv]
`timescale 1ns / 1ps
module mtbs_marks #(
  parameter int ROWS   = 1024,
  parameter int ROW_AW = 10
) (
  input  logic                clk,
  input  mtbs_pkg::mark_cmd_t cmd,
  input  logic [ROW_AW-1:0]   row,
  output logic                hit
);
  import mtbs_pkg::*;

  logic [MARK_ROW_W-1:0] mem [ROWS];
  logic [MARK_ROW_W-1:0] rdata;
  logic [MARK_ROW_W-1:0] bit_mask;

  assign bit_mask = MARK_ROW_W'(1) << cmd.bit_sel;
  assign hit      = rdata[cmd.bit_sel];

  // Single port: read a row, set a bit in the row just read, or clear a row
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      MARK_READ:  rdata    <= mem[row];
      MARK_SET:   mem[row] <= rdata | bit_mask;
      MARK_CLEAR: mem[row] <= '0;
      default: ;
    endcase
  end

endmodule

[rtl/core/mesh_triangle_box_select.sv]
`timescale 1ns / 1ps
// Channel   Direction  Signals                     Content
// s_axis    in         s_tvalid s_tready s_tdata   one mesh corner, s_tlast = final corner
// m_axis    out        m_tvalid m_tready m_tdata   one result per triangle, m_tlast = mesh done
// cfg       in         cfg_we cfg_index cfg_data   box, margin and check enable registers
//
// Sequence: each corner of a triangle is accepted in the idle state. After the third corner
// come a decide step and, when the face is kept, a read and a write-back of the
// single-port mark bitmap for each of three vertices; then the result is loaded.
// After the result that closes a mesh, and after reset, the bitmap is cleared one
// 64-bit row a cycle over ceil(min(MAX_VERTICES, 65536) / 64) rows, 1024 at the default.
// Reset is synchronous. A result waiting on m_tready does not block corners; only the
// load of the next result waits for the output register to empty.
module mesh_triangle_box_select #(
  parameter int MAX_VERTICES = mtbs_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // vertex_index[15:0], pos_x[39:16], pos_y[63:40], pos_z[87:64]
  input  logic [mtbs_pkg::S_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // face_kept[0], kept_face_count[17:1], marked_vertex_count[34:18],
  // no_vertex_error[35], zero[39:36]
  output logic [mtbs_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [mtbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mtbs_pkg::*;

  localparam int MARK_ENTRIES = (MAX_VERTICES < (1 << IDX_W)) ? MAX_VERTICES : (1 << IDX_W);
  localparam int ROWS   = (MARK_ENTRIES + MARK_ROW_W - 1) / MARK_ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  ctrl_state_t state, state_next;

  box_cfg_t box;

  logic [IDX_W-1:0]   held [3];
  logic [1:0]         phase;
  logic [1:0]         sel;
  logic               last_seen;
  logic               kept;
  logic [COUNT_W-1:0] face_tally;
  logic [COUNT_W-1:0] vertex_tally;
  logic [ROW_AW-1:0]  clr_row;

  logic               accept;
  logic               keep;
  logic               tri_clear;
  logic               out_load;
  logic               clr_last;
  logic [IDX_W-1:0]   sel_idx;
  logic               idx_ok;
  logic               hit;
  logic [ROW_AW-1:0]  mark_row;
  mark_cmd_t          mark_cmd;

  logic [IDX_W-1:0]        in_idx;
  logic signed [POS_W-1:0] in_x, in_y, in_z;

  assign in_idx = s_tdata[IDX_W-1:0];
  assign in_x   = s_tdata[IDX_W +: POS_W];
  assign in_y   = s_tdata[IDX_W+POS_W +: POS_W];
  assign in_z   = s_tdata[IDX_W+2*POS_W +: POS_W];

  assign accept   = s_tvalid && s_tready;
  assign clr_last = (clr_row == ROW_AW'(ROWS - 1));
  assign sel_idx  = held[sel];
  assign idx_ok   = (32'(sel_idx) < 32'(MAX_VERTICES));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      box.min_x    <= '0;
      box.min_y    <= '0;
      box.min_z    <= '0;
      box.max_x    <= '0;
      box.max_y    <= '0;
      box.max_z    <= '0;
      box.margin   <= EDGE_MARGIN_RESET;
      box.check_on <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_MIN_X:    box.min_x    <= cfg_data;
        REG_BOX_MIN_Y:    box.min_y    <= cfg_data;
        REG_BOX_MIN_Z:    box.min_z    <= cfg_data;
        REG_BOX_MAX_X:    box.max_x    <= cfg_data;
        REG_BOX_MAX_Y:    box.max_y    <= cfg_data;
        REG_BOX_MAX_Z:    box.max_z    <= cfg_data;
        REG_EDGE_MARGIN:  box.margin   <= cfg_data[MARGIN_W-1:0];
        REG_BOX_CHECK_ON: box.check_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (phase == 2'd2) state_next = S_DECIDE;
          else if (s_tlast)  state_next = S_EMIT;
        end
      end
      S_DECIDE:  state_next = keep ? S_MARK_RD : S_EMIT;
      S_MARK_RD: state_next = S_MARK_WR;
      S_MARK_WR: state_next = (sel == 2'd2) ? S_EMIT : S_MARK_RD;
      S_EMIT:    if (out_load) state_next = last_seen ? S_CLEAR : S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready      = 1'b0;
    out_load      = 1'b0;
    tri_clear     = 1'b0;
    mark_cmd.op   = MARK_NONE;
    mark_row      = ROW_AW'(sel_idx >> MARK_BIT_W);
    mark_cmd.bit_sel = sel_idx[MARK_BIT_W-1:0];
    unique case (state)
      S_CLEAR: begin
        mark_cmd.op = MARK_CLEAR;
        mark_row    = clr_row;
      end
      S_IDLE: begin
        s_tready  = 1'b1;
        tri_clear = accept && s_tlast && (phase != 2'd2);
      end
      S_DECIDE:  tri_clear = 1'b1;
      S_MARK_RD: if (idx_ok) mark_cmd.op = MARK_READ;
      S_MARK_WR: if (idx_ok && !hit) mark_cmd.op = MARK_SET;
      S_EMIT:    out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // State, triangle bookkeeping and tallies
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      phase        <= '0;
      sel          <= '0;
      last_seen    <= 1'b0;
      kept         <= 1'b0;
      face_tally   <= '0;
      vertex_tally <= '0;
      clr_row      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_row <= clr_row + ROW_AW'(1);
        S_IDLE: begin
          if (accept) begin
            held[phase] <= in_idx;
            last_seen   <= s_tlast;
            kept        <= 1'b0;
            phase       <= (phase == 2'd2 || s_tlast) ? 2'd0 : phase + 2'd1;
          end
        end
        S_DECIDE: begin
          kept <= keep;
          sel  <= '0;
          if (keep && face_tally < COUNT_W'(FACE_CAP)) face_tally <= face_tally + COUNT_W'(1);
        end
        S_MARK_WR: begin
          if (idx_ok && !hit) vertex_tally <= vertex_tally + COUNT_W'(1);
          sel <= (sel == 2'd2) ? 2'd0 : sel + 2'd1;
        end
        S_EMIT: begin
          if (out_load && last_seen) begin
            face_tally   <= '0;
            vertex_tally <= '0;
            clr_row      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0, last_seen && (vertex_tally == '0), vertex_tally, face_tally, kept};
      m_tlast <= last_seen;
    end
  end

  mtbs_geom u_geom (
    .clk         (clk),
    .rst         (rst),
    .corner_load (accept),
    .tri_clear   (tri_clear),
    .pos_x       (in_x),
    .pos_y       (in_y),
    .pos_z       (in_z),
    .box         (box),
    .keep        (keep)
  );

  mtbs_marks #(
    .ROWS   (ROWS),
    .ROW_AW (ROW_AW)
  ) u_marks (
    .clk (clk),
    .cmd (mark_cmd),
    .row (mark_row),
    .hit (hit)
  );

endmodule
